/* hdl/tvs_pkg.sv */
// tvs_pkg: shared types and constants of the trilinear volume sampler.
// No dependencies; imported by every module under hdl/.
package tvs_pkg;

	// Field widths fixed by the interface
	localparam int VAL_W    = 16;  // voxel and sample value
	localparam int VIDX_W   = 18;  // linear voxel index of a write
	localparam int COORD_W  = 15;  // signed fixed-point coordinate
	localparam int CFG_W    = 7;   // size register
	localparam int DIM_W    = 7;   // effective size and integer voxel position
	localparam int LIN_W    = 21;  // linear address computed for a sample
	localparam int APB_AW   = 4;
	localparam int APB_DW   = 32;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	// Register map (word index = paddr[3:2])
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_DEPTH  = 2'd2;

	// Input transaction kinds
	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Neighbour order is {z, y, x}; the last of the eight
	localparam logic [2:0] CORNER_LAST = 3'd7;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SETUP = 5'b00010,
		ST_READ  = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_FIN   = 5'b10000
	} state_t;

	// Tag travelling alongside each voxel read through the weighting pipeline
	typedef struct packed {
		logic       vld;
		logic       last;
		logic [2:0] corner;
	} pipe_ctl_t;

endpackage

/* hdl/trilinear_volume_sampler_unit.sv */
// trilinear_volume_sampler_unit: top level with APB size registers, the
// sample sequencer and output register. Depends on tvs_pkg, tvs_voxel_mem
// and tvs_weight_mac.
//
// Usage
//   Input channel (in_valid/in_stall): action 0 writes voxel_value at
//   voxel_index and gives no result; action 1 samples at coord_x/y/z
//   (signed, FRAC_BITS fraction bits) and gives one result.
//   Output channel (out_valid/out_stall): sample_value and out_of_range.
//   APB port: width, height, depth at byte addresses 0, 4, 8; change only
//   while the block is idle.
// Timing
//   A write goes straight into the voxel memory. A sample outside the
//   one-voxel margin goes straight to the result state, and the next
//   transaction is taken once its result is loaded into the output register.
//   An inside sample reads its eight neighbours one per cycle from the
//   single-port voxel memory, then passes three multiply stages and the
//   accumulator; the next transaction is taken as its result is loaded.
// Reset clears the size registers to 64 and empties the output register;
// the voxel store is not cleared and must be written before it is sampled.
// A stalled result waits in the output register while writes and the next
// sample proceed; a finished sample waits until that register frees.
module trilinear_volume_sampler_unit #(
	parameter int MAX_DIM   = 64,
	parameter int FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// APB
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [tvs_pkg::APB_AW-1:0]        paddr,
	input  logic [tvs_pkg::APB_DW-1:0]        pwdata,
	output logic [tvs_pkg::APB_DW-1:0]        prdata,
	output logic                              pready,
	// input channel
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [tvs_pkg::VIDX_W-1:0]        voxel_index,
	input  logic [tvs_pkg::VAL_W-1:0]         voxel_value,
	input  logic signed [tvs_pkg::COORD_W-1:0] coord_x,
	input  logic signed [tvs_pkg::COORD_W-1:0] coord_y,
	input  logic signed [tvs_pkg::COORD_W-1:0] coord_z,
	// output channel
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [tvs_pkg::VAL_W-1:0]         sample_value,
	output logic                              out_of_range
);
	import tvs_pkg::*;

	localparam int unsigned STORE_SIZE = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(STORE_SIZE);
	localparam int ONE    = 1 << FRAC_BITS;

	state_t st_q;
	logic [CFG_W-1:0] width_q, height_q, depth_q;
	logic [DIM_W-1:0] w_eff, h_eff, d_eff;
	logic cfg_wr;
	logic [1:0] cfg_idx;

	logic in_acc, oor_w, oor_q;
	logic signed [31:0] cx_ext, cy_ext, cz_ext;
	logic signed [31:0] cx_int, cy_int, cz_int;
	logic signed [31:0] w_hi, h_hi, d_hi;
	logic [DIM_W-1:0] ix_q, iy_q, iz_q;
	logic [FRAC_BITS-1:0] fx_q, fy_q, fz_q;

	logic [2*DIM_W-1:0] wh_q;
	logic [LIN_W-1:0] zb0_w, yb0_w;
	logic [LIN_W-1:0] zb0_q, zb1_q, yb0_q, yb1_q;
	logic [LIN_W-1:0] rd_lin;
	logic [31:0] rd_lin32, idx32;
	logic [2:0] corner_q;

	logic mem_we;
	logic [ADDR_W-1:0] mem_addr;
	logic [VAL_W-1:0] mem_rdata;
	pipe_ctl_t ctl_s1;

	logic mac_done;
	logic [VAL_W-1:0] mac_result;

	logic out_free, out_valid_q, oor_out_q;
	logic [VAL_W-1:0] value_out_q;

	// ---------------- configuration registers ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_RESET;
			height_q <= CFG_RESET;
			depth_q  <= CFG_RESET;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_WIDTH:  width_q  <= pwdata[CFG_W-1:0];
				REG_HEIGHT: height_q <= pwdata[CFG_W-1:0];
				REG_DEPTH:  depth_q  <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_WIDTH:  prdata = APB_DW'(width_q);
			REG_HEIGHT: prdata = APB_DW'(height_q);
			REG_DEPTH:  prdata = APB_DW'(depth_q);
			default:    prdata = '0;
		endcase
	end

	// Sizes saturate at the store dimension
	assign w_eff = (32'(width_q)  > MAX_DIM) ? DIM_W'(MAX_DIM) : width_q;
	assign h_eff = (32'(height_q) > MAX_DIM) ? DIM_W'(MAX_DIM) : height_q;
	assign d_eff = (32'(depth_q)  > MAX_DIM) ? DIM_W'(MAX_DIM) : depth_q;

	// ---------------- bounds check and split of coordinates ----------------
	assign cx_ext = 32'(coord_x);
	assign cy_ext = 32'(coord_y);
	assign cz_ext = 32'(coord_z);
	assign cx_int = cx_ext >>> FRAC_BITS;
	assign cy_int = cy_ext >>> FRAC_BITS;
	assign cz_int = cz_ext >>> FRAC_BITS;

	// Upper limit (size - 1) in fixed point; negative for size 0
	assign w_hi = ($signed(32'(w_eff)) - 32'sd1) <<< FRAC_BITS;
	assign h_hi = ($signed(32'(h_eff)) - 32'sd1) <<< FRAC_BITS;
	assign d_hi = ($signed(32'(d_eff)) - 32'sd1) <<< FRAC_BITS;

	assign oor_w = !((cx_ext >= ONE) && (cx_ext < w_hi) &&
	                 (cy_ext >= ONE) && (cy_ext < h_hi) &&
	                 (cz_ext >= ONE) && (cz_ext < d_hi));

	assign in_stall = !st_q[0];
	assign in_acc   = in_valid && !in_stall;

	// ---------------- address generation ----------------
	assign zb0_w = LIN_W'(iz_q) * LIN_W'(wh_q);
	assign yb0_w = LIN_W'(iy_q) * LIN_W'(w_eff);

	// Neighbour {c,b,a}: z base + y base + x
	assign rd_lin = (corner_q[2] ? zb1_q : zb0_q) + (corner_q[1] ? yb1_q : yb0_q)
	              + LIN_W'(ix_q) + LIN_W'(corner_q[0]);
	assign rd_lin32 = 32'(rd_lin);
	assign idx32    = 32'(voxel_index);

	assign mem_we   = in_acc && (action == ACT_WRITE) && (idx32 < STORE_SIZE);
	assign mem_addr = (st_q == ST_READ) ? rd_lin32[ADDR_W-1:0] : idx32[ADDR_W-1:0];

	tvs_voxel_mem #(
		.DEPTH  (STORE_SIZE),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (voxel_value),
		.rdata (mem_rdata)
	);

	tvs_weight_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (st_q == ST_SETUP),
		.ctl_in (ctl_s1),
		.voxel  (mem_rdata),
		.frac_x (fx_q),
		.frac_y (fy_q),
		.frac_z (fz_q),
		.result (mac_result),
		.done   (mac_done)
	);

	// ---------------- sequencer ----------------
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			corner_q    <= '0;
			oor_q       <= 1'b0;
			ctl_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// tag for the read issued this cycle, aligned with read data
			ctl_s1.vld    <= (st_q == ST_READ);
			ctl_s1.last   <= (st_q == ST_READ) && (corner_q == CORNER_LAST);
			ctl_s1.corner <= corner_q;

			// output register: load a finished sample, else empty once taken
			if ((st_q == ST_FIN) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (in_acc && (action == ACT_SAMPLE)) begin
						oor_q <= oor_w;
						st_q  <= oor_w ? ST_FIN : ST_SETUP;
					end
				end
				ST_SETUP: begin
					corner_q <= '0;
					st_q     <= ST_READ;
				end
				ST_READ: begin
					corner_q <= corner_q + 3'd1;
					if (corner_q == CORNER_LAST) begin
						st_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (mac_done) begin
						st_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Sample operands, row bases and result payload
	always_ff @(posedge clk) begin
		wh_q <= (2*DIM_W)'(w_eff) * (2*DIM_W)'(h_eff);
		if (in_acc) begin
			ix_q <= cx_int[DIM_W-1:0];
			iy_q <= cy_int[DIM_W-1:0];
			iz_q <= cz_int[DIM_W-1:0];
			fx_q <= cx_ext[FRAC_BITS-1:0];
			fy_q <= cy_ext[FRAC_BITS-1:0];
			fz_q <= cz_ext[FRAC_BITS-1:0];
		end
		if (st_q == ST_SETUP) begin
			zb0_q <= zb0_w;
			zb1_q <= zb0_w + LIN_W'(wh_q);
			yb0_q <= yb0_w;
			yb1_q <= yb0_w + LIN_W'(w_eff);
		end
		if ((st_q == ST_FIN) && out_free) begin
			value_out_q <= oor_q ? '0 : mac_result;
			oor_out_q   <= oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sample_value = value_out_q;
	assign out_of_range = oor_out_q;

	// ---------------- assertions ----------------
	a_oor_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (action == ACT_SAMPLE) && oor_w |=> st_q == ST_FIN)
		else $error("out-of-range sample did not go straight to result");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> sample_value == '0)
		else $error("flagged sample carries a non-zero value");

	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		mac_done |-> st_q == ST_DRAIN)
		else $error("accumulator finished outside the drain phase");

	a_read_in_store: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_READ |-> rd_lin32 < STORE_SIZE)
		else $error("neighbour address beyond the voxel store");

endmodule

/* hdl/tvs_voxel_mem.sv */
// tvs_voxel_mem: single-port voxel store, one access a cycle, registered read.
// Depends on tvs_pkg for the voxel width.
module tvs_voxel_mem #(
	parameter int DEPTH  = 262144,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [ADDR_W-1:0]         addr,
	input  logic [tvs_pkg::VAL_W-1:0] wdata,
	output logic [tvs_pkg::VAL_W-1:0] rdata
);
	import tvs_pkg::*;

	logic [VAL_W-1:0] mem_q [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	// Write when enabled, and read, at the shared address
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

/* hdl/tvs_weight_mac.sv */
// tvs_weight_mac: weights each voxel read by wx*wy*wz over three multiply
// stages and accumulates the eight terms. Depends on tvs_pkg.
module tvs_weight_mac #(
	parameter int FRAC_BITS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clr,
	input  tvs_pkg::pipe_ctl_t        ctl_in,
	input  logic [tvs_pkg::VAL_W-1:0] voxel,
	input  logic [FRAC_BITS-1:0]      frac_x,
	input  logic [FRAC_BITS-1:0]      frac_y,
	input  logic [FRAC_BITS-1:0]      frac_z,
	output logic [tvs_pkg::VAL_W-1:0] result,
	output logic                      done
);
	import tvs_pkg::*;

	localparam int WT_W = FRAC_BITS + 1;
	localparam int M1_W = VAL_W + FRAC_BITS;
	localparam int M2_W = VAL_W + 2 * FRAC_BITS;
	localparam int M3_W = VAL_W + 3 * FRAC_BITS;
	localparam logic [WT_W-1:0] WT_ONE = {1'b1, {FRAC_BITS{1'b0}}};

	pipe_ctl_t ctl_s2, ctl_s3, ctl_s4;
	logic [WT_W-1:0] wx_sel, wy_sel, wz_sel;
	logic [VAL_W+WT_W-1:0] m1_full;
	logic [M1_W+WT_W-1:0]  m2_full;
	logic [M2_W+WT_W-1:0]  m3_full;
	logic [M1_W-1:0] m1_s2;
	logic [M2_W-1:0] m2_s3;
	logic [M3_W-1:0] m3_s4;
	logic [M3_W-1:0] acc_q;

	// Floor neighbour gets one minus the fraction, the upper one the fraction
	assign wx_sel = ctl_in.corner[0] ? {1'b0, frac_x} : WT_ONE - {1'b0, frac_x};
	assign wy_sel = ctl_s2.corner[1] ? {1'b0, frac_y} : WT_ONE - {1'b0, frac_y};
	assign wz_sel = ctl_s3.corner[2] ? {1'b0, frac_z} : WT_ONE - {1'b0, frac_z};

	// One multiplier per stage; products never exceed value * 2^(k*FRAC_BITS)
	assign m1_full = (VAL_W + WT_W)'(voxel) * (VAL_W + WT_W)'(wx_sel);
	assign m2_full = (M1_W + WT_W)'(m1_s2) * (M1_W + WT_W)'(wy_sel);
	assign m3_full = (M2_W + WT_W)'(m2_s3) * (M2_W + WT_W)'(wz_sel);

	// Stage tags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s2 <= ctl_in;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// Products and running sum
	always_ff @(posedge clk) begin
		m1_s2 <= m1_full[M1_W-1:0];
		m2_s3 <= m2_full[M2_W-1:0];
		m3_s4 <= m3_full[M3_W-1:0];
		if (clr) begin
			acc_q <= '0;
		end else if (ctl_s4.vld) begin
			acc_q <= acc_q + m3_s4;
		end
	end

	// Sum of weights is 2^(3*FRAC_BITS): drop the fraction, keep 16 bits
	assign result = acc_q[M3_W-1 -: VAL_W];
	assign done   = ctl_s4.vld & ctl_s4.last;

endmodule
